>>> hw/rtl/psu_pkg.sv
// Shared types and constants for the PNG scanline unfilter.
// Used by every module of the block; the channel interfaces do not depend on it.
package psu_pkg;

    localparam int MAX_ROW_BYTES_DEF   = 4096;
    localparam int MAX_PIXEL_BYTES_DEF = 8;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd0;
    localparam logic [1:0] REG_ROW_BYTES       = 2'd1;
    localparam logic [1:0] REG_IMAGE_ROWS      = 2'd2;

    localparam logic [3:0]  BPP_RESET        = 4'd4;
    localparam logic [12:0] ROW_BYTES_RESET  = 13'd4096;
    localparam logic [15:0] IMAGE_ROWS_RESET = 16'd1;

    localparam logic [7:0] FILT_NONE    = 8'd0;
    localparam logic [7:0] FILT_SUB     = 8'd1;
    localparam logic [7:0] FILT_UP      = 8'd2;
    localparam logic [7:0] FILT_AVERAGE = 8'd3;
    localparam logic [7:0] FILT_PAETH   = 8'd4;

    typedef struct packed {
        logic [3:0]  bytes_per_pixel;
        logic [12:0] row_bytes;
        logic [15:0] image_rows;
    } cfg_t;

    // Control from the sequencer to the reconstruction stage for one beat.
    typedef struct packed {
        logic data_load;
        logic filter_load;
        logic up_valid;
        logic row_end;
        logic image_end;
    } seq_ctl_t;

endpackage

>>> hw/rtl/psu_if.sv
// Valid/ready channels of the PNG scanline unfilter.
// Payload widths are fixed by the stream format; no package dependency.
interface psu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface psu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] recon_byte;
    logic       row_end;
    logic       image_end;

    modport source (output valid, output recon_byte, output row_end, output image_end,
                    input ready);
    modport sink (input valid, input recon_byte, input row_end, input image_end,
                  output ready);
endinterface

>>> hw/rtl/psu_cfg.sv
// APB-style register file: bytes_per_pixel, row_bytes, image_rows.
// Depends on psu_pkg for the register map and reset values.
module psu_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psu_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [psu_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [psu_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output psu_pkg::cfg_t                   cfg
);

    psu_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bytes_per_pixel <= psu_pkg::BPP_RESET;
            cfg_reg.row_bytes       <= psu_pkg::ROW_BYTES_RESET;
            cfg_reg.image_rows      <= psu_pkg::IMAGE_ROWS_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                psu_pkg::REG_BYTES_PER_PIXEL: cfg_reg.bytes_per_pixel <= pwdata[3:0];
                psu_pkg::REG_ROW_BYTES:       cfg_reg.row_bytes       <= pwdata[12:0];
                psu_pkg::REG_IMAGE_ROWS:      cfg_reg.image_rows      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            psu_pkg::REG_BYTES_PER_PIXEL: prdata = {28'd0, cfg_reg.bytes_per_pixel};
            psu_pkg::REG_ROW_BYTES:       prdata = {19'd0, cfg_reg.row_bytes};
            psu_pkg::REG_IMAGE_ROWS:      prdata = {16'd0, cfg_reg.image_rows};
            default:                      prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/psu_seq.sv
// Stream sequencer: splits filter bytes from data bytes and tracks column and row.
// Depends on psu_pkg and the psu_in_if channel.
module psu_seq #(
    parameter int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF,
    localparam int COL_W = $clog2(MAX_ROW_BYTES)
) (
    input  logic              clk,
    input  logic              rst_n,
    psu_in_if.sink            pix_in,
    input  psu_pkg::cfg_t     cfg,
    input  logic              take_ok,
    output psu_pkg::seq_ctl_t ctl,
    output logic [COL_W-1:0]  col,
    output logic [7:0]        data_byte
);

    localparam int LEN_W = ($clog2(MAX_ROW_BYTES + 1) > 13) ? $clog2(MAX_ROW_BYTES + 1) : 13;

    logic             awaiting_reg, awaiting_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [15:0]      row_reg, row_next;

    logic             accept;
    logic             is_filter;
    logic [LEN_W-1:0] row_len_raw;
    logic [LEN_W-1:0] row_len;
    logic [LEN_W-1:0] col_inc;
    logic [15:0]      rows_eff;
    logic [15:0]      row_inc;
    logic             row_end;
    logic             image_end;

    assign pix_in.ready = take_ok;
    assign accept       = pix_in.valid & take_ok;
    assign is_filter    = awaiting_reg | pix_in.frame_start;

    assign row_len_raw = LEN_W'(cfg.row_bytes);
    always_comb
    begin
        if (row_len_raw == '0)
            row_len = LEN_W'(1);
        else if (row_len_raw > LEN_W'(MAX_ROW_BYTES))
            row_len = LEN_W'(MAX_ROW_BYTES);
        else
            row_len = row_len_raw;
    end

    assign rows_eff  = (cfg.image_rows == 16'd0) ? 16'd1 : cfg.image_rows;
    assign col_inc   = LEN_W'(col_reg) + LEN_W'(1);
    assign row_inc   = row_reg + 16'd1;
    assign row_end   = (col_inc >= row_len);
    // The row counter wraps after the last row so the next byte opens a new image.
    assign image_end = row_end & ((row_inc >= rows_eff) | (row_inc == 16'd0));

    always_comb
    begin
        awaiting_next = awaiting_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        if (accept)
        begin
            if (is_filter)
            begin
                awaiting_next = 1'b0;
                col_next      = '0;
                if (pix_in.frame_start)
                    row_next = 16'd0;
            end
            else if (row_end)
            begin
                awaiting_next = 1'b1;
                col_next      = '0;
                row_next      = image_end ? 16'd0 : row_inc;
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b1;
            col_reg      <= '0;
            row_reg      <= 16'd0;
        end
        else
        begin
            awaiting_reg <= awaiting_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
        end
    end

    assign ctl.data_load   = accept & ~is_filter;
    assign ctl.filter_load = accept & is_filter;
    assign ctl.up_valid    = (row_reg != 16'd0);
    assign ctl.row_end     = row_end;
    assign ctl.image_end   = image_end;
    assign col             = col_reg;
    assign data_byte       = pix_in.data_byte;

endmodule

>>> hw/rtl/psu_predict.sv
// Filter arithmetic: none, sub, up, average and Paeth on one byte.
// Depends on psu_pkg for the filter type codes.
module psu_predict (
    input  logic [7:0] filter_type,
    input  logic [7:0] x,
    input  logic [7:0] a,
    input  logic [7:0] b,
    input  logic [7:0] c,
    output logic [7:0] r
);

    logic signed [9:0] d_ac, d_bc, d_sum;
    logic        [9:0] pa, pb, pc;
    logic        [7:0] paeth;
    logic        [8:0] ab_sum;

    // With p = a + b - c: |p - a| = |b - c|, |p - b| = |a - c|, |p - c| = |a + b - 2c|.
    assign d_ac  = $signed({2'b00, a}) - $signed({2'b00, c});
    assign d_bc  = $signed({2'b00, b}) - $signed({2'b00, c});
    assign d_sum = d_ac + d_bc;
    assign pa    = d_bc[9]  ? 10'(-d_bc)  : 10'(d_bc);
    assign pb    = d_ac[9]  ? 10'(-d_ac)  : 10'(d_ac);
    assign pc    = d_sum[9] ? 10'(-d_sum) : 10'(d_sum);

    always_comb
    begin
        if ((pa <= pb) && (pa <= pc))
            paeth = a;
        else if (pb <= pc)
            paeth = b;
        else
            paeth = c;
    end

    assign ab_sum = {1'b0, a} + {1'b0, b};

    always_comb
    begin
        case (filter_type)
            psu_pkg::FILT_NONE:    r = x;
            psu_pkg::FILT_SUB:     r = x + a;
            psu_pkg::FILT_UP:      r = x + b;
            psu_pkg::FILT_AVERAGE: r = x + ab_sum[8:1];
            psu_pkg::FILT_PAETH:   r = x + paeth;
            default:               r = x;
        endcase
    end

endmodule

>>> hw/rtl/psu_recon.sv
// Reconstruction stage: line store, neighbor history, filter math and result register.
// Depends on psu_pkg, psu_predict and the psu_out_if channel.
module psu_recon #(
    parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF,
    localparam int COL_W = $clog2(MAX_ROW_BYTES)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  psu_pkg::cfg_t     cfg,
    input  psu_pkg::seq_ctl_t ctl,
    input  logic [COL_W-1:0]  col,
    input  logic [7:0]        data_byte,
    output logic              take_ok,
    psu_out_if.source         pix_out
);

    localparam int PIX_IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    logic [7:0] line_mem [MAX_ROW_BYTES];
    logic [7:0] up_rd_reg;

    logic             s1_valid_reg;
    logic [7:0]       s1_byte_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_up_valid_reg;
    logic             s1_row_end_reg;
    logic             s1_image_end_reg;

    logic [7:0] filter_reg;
    logic [7:0] left_hist_reg [MAX_PIXEL_BYTES];
    logic [7:0] upleft_hist_reg [MAX_PIXEL_BYTES];

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_row_end_reg;
    logic       out_image_end_reg;

    logic                 s1_move;
    logic [3:0]           pix_dist;
    logic [3:0]           pix_dist_m1;
    logic [PIX_IDX_W-1:0] hist_idx;
    logic [7:0]           a, b, c, r;

    assign s1_move = s1_valid_reg & (~out_valid_reg | pix_out.ready);
    assign take_ok = ~s1_valid_reg | s1_move;

    always_comb
    begin
        if (cfg.bytes_per_pixel == 4'd0)
            pix_dist = 4'd1;
        else if (cfg.bytes_per_pixel > 4'(MAX_PIXEL_BYTES))
            pix_dist = 4'(MAX_PIXEL_BYTES);
        else
            pix_dist = cfg.bytes_per_pixel;
    end
    assign pix_dist_m1 = pix_dist - 4'd1;
    assign hist_idx    = pix_dist_m1[PIX_IDX_W-1:0];

    assign a = left_hist_reg[hist_idx];
    assign c = upleft_hist_reg[hist_idx];
    assign b = s1_up_valid_reg ? up_rd_reg : 8'd0;

    psu_predict u_predict (
        .filter_type (filter_reg),
        .x           (s1_byte_reg),
        .a           (a),
        .b           (b),
        .c           (c),
        .r           (r)
    );

    // A column is read again only one row later, after at least the filter byte,
    // so the write of a result never meets a read of the same entry.
    always_ff @(posedge clk)
    begin
        if (s1_move)
            line_mem[s1_col_reg] <= r;
        if (ctl.data_load)
            up_rd_reg <= line_mem[col];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (ctl.data_load)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.data_load)
        begin
            s1_byte_reg      <= data_byte;
            s1_col_reg       <= col;
            s1_up_valid_reg  <= ctl.up_valid;
            s1_row_end_reg   <= ctl.row_end;
            s1_image_end_reg <= ctl.image_end;
        end
    end

    // A filter byte clears the history; it wins over the push of the last beat
    // of the previous row leaving at the same edge.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg <= psu_pkg::FILT_NONE;
            for (int i = 0; i < MAX_PIXEL_BYTES; i++)
            begin
                left_hist_reg[i]   <= 8'd0;
                upleft_hist_reg[i] <= 8'd0;
            end
        end
        else if (ctl.filter_load)
        begin
            filter_reg <= data_byte;
            for (int i = 0; i < MAX_PIXEL_BYTES; i++)
            begin
                left_hist_reg[i]   <= 8'd0;
                upleft_hist_reg[i] <= 8'd0;
            end
        end
        else if (s1_move)
        begin
            left_hist_reg[0]   <= r;
            upleft_hist_reg[0] <= b;
            for (int i = 1; i < MAX_PIXEL_BYTES; i++)
            begin
                left_hist_reg[i]   <= left_hist_reg[i-1];
                upleft_hist_reg[i] <= upleft_hist_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_move)
            out_valid_reg <= 1'b1;
        else if (pix_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_byte_reg      <= r;
            out_row_end_reg   <= s1_row_end_reg;
            out_image_end_reg <= s1_image_end_reg;
        end
    end

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.recon_byte = out_byte_reg;
    assign pix_out.row_end    = out_row_end_reg;
    assign pix_out.image_end  = out_image_end_reg;

endmodule

>>> hw/rtl/png_scanline_unfilter.sv
// PNG scanline unfilter: one stream byte per cycle while the output accepts, one result per data byte.
// The data byte and the line store read are registered into the working stage, then the
// result goes into the result register, which drives the output channel.
// Throughput is one beat per cycle while the output is not stalled; filter bytes give no result.
// Reset clears the counters and histories; the first beat is taken as a filter code.
// The line store is not cleared; an entry is used only after the previous row wrote it.
module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    psu_in_if.sink                          pix_in,
    psu_out_if.source                       pix_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psu_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [psu_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [psu_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int COL_W = $clog2(MAX_ROW_BYTES);

    psu_pkg::cfg_t     cfg;
    psu_pkg::seq_ctl_t ctl;
    logic [COL_W-1:0]  col;
    logic [7:0]        data_byte;
    logic              take_ok;

    psu_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    psu_seq #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in),
        .cfg       (cfg),
        .take_ok   (take_ok),
        .ctl       (ctl),
        .col       (col),
        .data_byte (data_byte)
    );

    psu_recon #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_recon (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .ctl       (ctl),
        .col       (col),
        .data_byte (data_byte),
        .take_ok   (take_ok),
        .pix_out   (pix_out)
    );

endmodule

>>> tb/psu_unfilter_check.sv
// Checker for the PNG scanline unfilter: predicts each reconstructed beat and compares.
// Watches both byte channels and the APB port; depends on psu_pkg and the psu_if interfaces.
`timescale 1ns / 100ps
module psu_unfilter_check (
    input  logic                           clk,
    input  logic                           rst_n,
    psu_in_if                              pix_in,
    psu_out_if                             pix_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [psu_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [psu_pkg::APB_DATA_W-1:0] pwdata,
    input  logic [psu_pkg::APB_DATA_W-1:0] prdata,
    input  logic                           pready,
    output int                             recon_pending,
    output int                             mismatch_count
);

    typedef struct packed {
        logic [7:0] pix;
        logic       last_in_row;
        logic       last_in_image;
    } recon_beat_t;

    psu_pkg::cfg_t fmt;
    logic [7:0]    line_mem [psu_pkg::MAX_ROW_BYTES_DEF];
    logic [7:0]    left_hist [psu_pkg::MAX_PIXEL_BYTES_DEF];
    logic [7:0]    upleft_hist [psu_pkg::MAX_PIXEL_BYTES_DEF];
    logic [12:0]   col_cnt;
    logic [15:0]   row_cnt;
    logic          await_code;
    logic [7:0]    filter_code;
    recon_beat_t   recon_due [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t recon_check: %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [7:0] paeth_predictor(input logic [7:0] a, input logic [7:0] b,
                                                   input logic [7:0] c);
        int ia, ib, ic, p, pa, pb, pc;
        ia = a;
        ib = b;
        ic = c;
        p  = ia + ib - ic;
        pa = (p > ia) ? p - ia : ia - p;
        pb = (p > ib) ? p - ib : ib - p;
        pc = (p > ic) ? p - ic : ic - p;
        if (pa <= pb && pa <= pc)
            return a;
        if (pb <= pc)
            return b;
        return c;
    endfunction

    task automatic clear_history();
        for (int k = 0; k < psu_pkg::MAX_PIXEL_BYTES_DEF; k++)
        begin
            left_hist[k]   = 8'd0;
            upleft_hist[k] = 8'd0;
        end
    endtask

    // Advance the prediction by one accepted input beat.
    task automatic unfilter_step(input logic [7:0] x, input logic frame_start);
        int          pix_dist, row_len, rows, col;
        logic [7:0]  a, b, c, r;
        logic [8:0]  sum;
        recon_beat_t beat;
        if (frame_start)
        begin
            row_cnt    = '0;
            await_code = 1'b1;
        end
        if (await_code)
        begin
            filter_code = x;
            await_code  = 1'b0;
            col_cnt     = '0;
            clear_history();
            return;
        end

        pix_dist = (fmt.bytes_per_pixel == 0) ? 1 :
                   (fmt.bytes_per_pixel > psu_pkg::MAX_PIXEL_BYTES_DEF) ?
                   psu_pkg::MAX_PIXEL_BYTES_DEF : fmt.bytes_per_pixel;
        row_len = (fmt.row_bytes == 0) ? 1 :
                  (fmt.row_bytes > psu_pkg::MAX_ROW_BYTES_DEF) ?
                  psu_pkg::MAX_ROW_BYTES_DEF : fmt.row_bytes;
        rows = (fmt.image_rows == 0) ? 1 : fmt.image_rows;
        col  = (col_cnt >= psu_pkg::MAX_ROW_BYTES_DEF) ?
               psu_pkg::MAX_ROW_BYTES_DEF - 1 : col_cnt;

        a = left_hist[pix_dist-1];
        c = upleft_hist[pix_dist-1];
        b = (row_cnt != 0) ? line_mem[col] : 8'd0;
        sum = {1'b0, a} + {1'b0, b};

        case (filter_code)
            psu_pkg::FILT_SUB:     r = x + a;
            psu_pkg::FILT_UP:      r = x + b;
            psu_pkg::FILT_AVERAGE: r = x + sum[8:1];
            psu_pkg::FILT_PAETH:   r = x + paeth_predictor(a, b, c);
            default:               r = x;
        endcase

        line_mem[col] = r;
        for (int k = psu_pkg::MAX_PIXEL_BYTES_DEF - 1; k > 0; k--)
        begin
            left_hist[k]   = left_hist[k-1];
            upleft_hist[k] = upleft_hist[k-1];
        end
        left_hist[0]   = r;
        upleft_hist[0] = b;

        beat.pix           = r;
        beat.last_in_row   = 1'b0;
        beat.last_in_image = 1'b0;
        col_cnt = 13'(col + 1);
        if (col_cnt >= row_len)
        begin
            beat.last_in_row = 1'b1;
            col_cnt    = '0;
            await_code = 1'b1;
            row_cnt    = row_cnt + 16'd1;
            if (row_cnt >= rows || row_cnt == 0)
            begin
                beat.last_in_image = 1'b1;
                row_cnt = '0;
            end
        end
        recon_due.push_back(beat);
    endtask

    task automatic compare_beat();
        recon_beat_t want;
        if (recon_due.size() == 0)
        begin
            report_mismatch("beat with nothing expected", 32'(pix_out.recon_byte), 32'd0);
            return;
        end
        want = recon_due.pop_front();
        if (pix_out.recon_byte !== want.pix)
            report_mismatch("recon_byte", 32'(pix_out.recon_byte), 32'(want.pix));
        if (pix_out.row_end !== want.last_in_row)
            report_mismatch("row_end", 32'(pix_out.row_end), 32'(want.last_in_row));
        if (pix_out.image_end !== want.last_in_image)
            report_mismatch("image_end", 32'(pix_out.image_end), 32'(want.last_in_image));
    endtask

    task automatic apb_transfer();
        logic [31:0] held;
        case (paddr[3:2])
            psu_pkg::REG_BYTES_PER_PIXEL: held = {28'd0, fmt.bytes_per_pixel};
            psu_pkg::REG_ROW_BYTES:       held = {19'd0, fmt.row_bytes};
            psu_pkg::REG_IMAGE_ROWS:      held = {16'd0, fmt.image_rows};
            default:                      held = 32'd0;
        endcase
        if (!pwrite)
        begin
            if (prdata !== held)
                report_mismatch("register readback", prdata, held);
            return;
        end
        case (paddr[3:2])
            psu_pkg::REG_BYTES_PER_PIXEL: fmt.bytes_per_pixel = pwdata[3:0];
            psu_pkg::REG_ROW_BYTES:       fmt.row_bytes       = pwdata[12:0];
            psu_pkg::REG_IMAGE_ROWS:      fmt.image_rows      = pwdata[15:0];
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt.bytes_per_pixel = psu_pkg::BPP_RESET;
            fmt.row_bytes       = psu_pkg::ROW_BYTES_RESET;
            fmt.image_rows      = psu_pkg::IMAGE_ROWS_RESET;
            clear_history();
            col_cnt        = '0;
            row_cnt        = '0;
            await_code     = 1'b1;
            filter_code    = psu_pkg::FILT_NONE;
            mismatch_count = 0;
            recon_due.delete();
            recon_pending <= 0;
        end
        else
        begin
            if (pix_out.valid === 1'b1 && pix_out.ready === 1'b1)
                compare_beat();
            if (pix_in.valid === 1'b1 && pix_in.ready === 1'b1)
                unfilter_step(pix_in.data_byte, pix_in.frame_start);
            if (psel && penable && pready === 1'b1)
                apb_transfer();
            recon_pending <= recon_due.size();
        end
    end

endmodule

>>> tb/tb_png_scanline_unfilter.sv
// Testbench top for the PNG scanline unfilter: drives image byte streams and register setups.
// Depends on psu_pkg, the psu_if interfaces, the block and psu_unfilter_check.
`timescale 1ns / 100ps
module tb_png_scanline_unfilter;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          SETTLE_CYCLES = 4;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    psu_in_if  pix_in ();
    psu_out_if pix_out ();

    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [psu_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [psu_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [psu_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    int          recon_pending;
    int          mismatch_count;
    int unsigned cycles = 0;
    int          stall_mode = 0;
    int unsigned stall_tick = 0;

    // Sender pacing and the stream layout tracker used to place filter codes.
    int gap_max    = 0;
    int burst_left = 0;
    bit sending    = 1'b0;
    bit gen_await  = 1'b1;
    int gen_col    = 0;
    int gen_len    = 1;

    png_scanline_unfilter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .pix_out (pix_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    psu_unfilter_check recon_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .pix_in         (pix_in),
        .pix_out        (pix_out),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .recon_pending  (recon_pending),
        .mismatch_count (mismatch_count)
    );

    always #1 clk = ~clk;

    initial
    begin
        pix_in.valid       = 1'b0;
        pix_in.data_byte   = 8'd0;
        pix_in.frame_start = 1'b0;
        pix_out.ready      = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_png_scanline_unfilter: done, errors");
            $finish;
        end
    end

    // Receiver stall patterns: always ready, random, long periodic stalls, coin flip.
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            0:       pix_out.ready <= 1'b1;
            1:       pix_out.ready <= ($urandom_range(0, 3) != 0);
            2:       pix_out.ready <= ((stall_tick % 11) >= 4);
            default: pix_out.ready <= 1'($urandom_range(0, 1));
        endcase
    end

    task automatic apb_cycle(input logic wr, input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_format(input int bpp, input int row_len, input int rows);
        apb_cycle(1'b1, psu_pkg::REG_BYTES_PER_PIXEL, bpp);
        apb_cycle(1'b1, psu_pkg::REG_ROW_BYTES, row_len);
        apb_cycle(1'b1, psu_pkg::REG_IMAGE_ROWS, rows);
        apb_cycle(1'b0, psu_pkg::REG_BYTES_PER_PIXEL, 0);
        apb_cycle(1'b0, psu_pkg::REG_ROW_BYTES, 0);
        apb_cycle(1'b0, psu_pkg::REG_IMAGE_ROWS, 0);
        gen_len = (row_len == 0) ? 1 :
                  (row_len > psu_pkg::MAX_ROW_BYTES_DEF) ? psu_pkg::MAX_ROW_BYTES_DEF : row_len;
    endtask

    task automatic set_pace(input int gap, input int stall);
        gap_max    = gap;
        burst_left = 0;
        stall_mode <= stall;
    endtask

    // One beat on the input channel, then possibly a gap before the next burst.
    task automatic push_byte(input logic [7:0] b, input logic fs);
        int gap;
        pix_in.valid       <= 1'b1;
        pix_in.data_byte   <= b;
        pix_in.frame_start <= fs;
        sending = 1'b1;
        @(posedge clk);
        while (pix_in.ready !== 1'b1)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 40);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                pix_in.valid <= 1'b0;
                sending = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop sending, wait for every predicted beat, then let the block settle.
    task automatic wait_drained();
        if (sending)
        begin
            pix_in.valid <= 1'b0;
            sending = 1'b0;
        end
        do
            @(posedge clk);
        while (recon_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Well-formed rows with random filter codes and data; noise_rate > 0 adds
    // stray frame starts that cut an image short.
    task automatic stream_images(input int count, input int noise_rate, input int hold_at);
        logic [7:0] b;
        logic       fs;
        int         pick;
        for (int i = 0; i < count; i++)
        begin
            fs = (i == 0) || (noise_rate > 0 && $urandom_range(0, noise_rate - 1) == 0);
            if (fs)
                gen_await = 1'b1;
            if (gen_await)
            begin
                b = ($urandom_range(0, 9) < 8) ?
                    8'($urandom_range(psu_pkg::FILT_NONE, psu_pkg::FILT_PAETH)) :
                    8'($urandom_range(0, 255));
                gen_await = 1'b0;
                gen_col   = 0;
            end
            else
            begin
                pick = $urandom_range(0, 7);
                b = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 255));
                gen_col++;
                if (gen_col >= gen_len)
                    gen_await = 1'b1;
            end
            if (i == hold_at)
                wait_drained();
            push_byte(b, fs);
        end
    endtask

    // Six short rows, one per filter type plus an unknown code, at a two-byte pixel.
    logic [7:0] opening_bytes [24] = '{
        psu_pkg::FILT_NONE,    8'd255, 8'd254, 8'd1,
        psu_pkg::FILT_SUB,     8'd255, 8'd1,   8'd0,
        psu_pkg::FILT_UP,      8'd255, 8'd255, 8'd2,
        psu_pkg::FILT_AVERAGE, 8'd0,   8'd255, 8'd3,
        psu_pkg::FILT_PAETH,   8'd255, 8'd0,   8'd7,
        8'd255,                8'd9,   8'd8,   8'd0
    };

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_format(2, 3, 6);
        set_pace(0, 0);
        for (int k = 0; k < 24; k++)
            push_byte(opening_bytes[k], k == 0);
        wait_drained();

        set_format(1, 5, 4);
        set_pace(3, 1);
        stream_images(90, 60, 45);
        wait_drained();

        set_format(8, 17, 3);
        set_pace(0, 0);
        stream_images(90, 0, -1);
        wait_drained();

        // Zero in every register acts as one.
        set_format(0, 0, 0);
        set_pace(5, 2);
        stream_images(60, 30, -1);
        wait_drained();

        set_format(15, 9, 65535);
        set_pace(2, 3);
        stream_images(90, 50, -1);
        wait_drained();

        set_format(3, 12, 2);
        set_pace(8, 1);
        stream_images(90, 40, -1);
        wait_drained();

        repeat (2)
        begin
            set_format($urandom_range(1, 8), $urandom_range(1, 40), $urandom_range(1, 6));
            set_pace($urandom_range(0, 6), $urandom_range(0, 3));
            stream_images(90, 50, -1);
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("tb_png_scanline_unfilter: done, clean");
        else
            $display("tb_png_scanline_unfilter: done, errors");
        $finish;
    end

endmodule
